// File: design/probe_touch_off_sequencer_assert.svh
// Assertion macros for the probe touch-off sequencer.
`ifndef PROBE_TOUCH_OFF_SEQUENCER_ASSERT_SVH
`define PROBE_TOUCH_OFF_SEQUENCER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PTOS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PTOS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/ptos_pkg.sv
// Package: payload types and codes for the probe touch-off sequencer.
`timescale 1ns / 1ps

package ptos_pkg;

   localparam int TICK_BITS_DEFAULT = 20;
   localparam int TIMEOUT_W = 20;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd90000;

   // Request codes
   localparam logic [2:0] FUNC_START      = 3'd0;
   localparam logic [2:0] FUNC_CANCEL     = 3'd1;
   localparam logic [2:0] FUNC_POLL       = 3'd2;
   localparam logic [2:0] FUNC_SET_HERE   = 3'd3;
   localparam logic [2:0] FUNC_INVALIDATE = 3'd4;
   localparam logic [2:0] FUNC_TICK       = 3'd5;

   // Machine state codes
   localparam logic [1:0] MACH_IDLE  = 2'd0;
   localparam logic [1:0] MACH_ALARM = 2'd1;

   // Commands
   localparam logic [2:0] CMD_NONE       = 3'd0;
   localparam logic [2:0] CMD_FAST_PROBE = 3'd1;
   localparam logic [2:0] CMD_RETRACT    = 3'd2;
   localparam logic [2:0] CMD_SLOW_PROBE = 3'd3;
   localparam logic [2:0] CMD_APPLY      = 3'd4;
   localparam logic [2:0] CMD_SET_HERE   = 3'd5;
   localparam logic [2:0] CMD_FEED_HOLD  = 3'd6;

   // Zero lost reasons
   localparam logic [2:0] WHY_NEVER_SET    = 3'd0;
   localparam logic [2:0] WHY_PROBE_FAILED = 3'd5;
   localparam logic [2:0] WHY_CANCELLED    = 3'd6;
   localparam logic [2:0] WHY_UNDEFINED    = 3'd7;

   // Failure codes
   localparam logic [3:0] FAIL_NONE         = 4'd0;
   localparam logic [3:0] FAIL_NO_LINK      = 4'd1;
   localparam logic [3:0] FAIL_ALARM        = 4'd2;
   localparam logic [3:0] FAIL_NOT_IDLE     = 4'd3;
   localparam logic [3:0] FAIL_LINK_LOST    = 4'd4;
   localparam logic [3:0] FAIL_CTRL_ERROR   = 4'd5;
   localparam logic [3:0] FAIL_TIMEOUT      = 4'd6;
   localparam logic [3:0] FAIL_NO_FAST      = 4'd7;
   localparam logic [3:0] FAIL_NO_SLOW      = 4'd8;
   localparam logic [3:0] FAIL_SET_UNPROBED = 4'd9;

   typedef struct packed {
      logic [2:0] func;
      logic       link_up;
      logic [1:0] machine_state;
      logic       queue_synced;
      logic       motion_error;
      logic       probe_result_ready;
      logic       probe_triggered;
      logic [2:0] lost_cause;
   } req_type;

   typedef struct packed {
      logic       accepted;
      logic [2:0] command;
      logic       clear_error;
      logic [2:0] seq_state;
      logic       zero_valid;
      logic [2:0] lost_reason;
      logic [3:0] fail_code;
   } rsp_type;

endpackage

// File: design/probe_touch_off_sequencer.sv
// Top level: two-touch Z probe touch-off sequencer.
// The response is registered: rsp_valid rises in the cycle after a request is accepted.
// Throughput: one request per cycle while responses are taken; the sequence state updates at the accept edge.
// A request is taken while a response waits only if that response is taken too.
// Reset (synchronous): state idle, zero invalid, no failure, tick count 0, timeout 90000.
`timescale 1ns / 1ps
`include "probe_touch_off_sequencer_assert.svh"

module probe_touch_off_sequencer #(
   parameter int TICK_COUNTER_BITS = ptos_pkg::TICK_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  ptos_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ptos_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [ptos_pkg::TIMEOUT_W-1:0]    csr_wr_data
);
   import ptos_pkg::*;

   localparam int CMP_W = (TICK_COUNTER_BITS > TIMEOUT_W) ? TICK_COUNTER_BITS : TIMEOUT_W;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_FAST    = 3'd1,
      ST_RETRACT = 3'd2,
      ST_SLOW    = 3'd3,
      ST_APPLY   = 3'd4,
      ST_DONE    = 3'd5,
      ST_FAILED  = 3'd6
   } state_type;

   state_type                    state_ff, state_in;
   logic                         zero_valid_ff, zero_valid_in;
   logic [2:0]                   lost_reason_ff, lost_reason_in;
   logic [3:0]                   fail_code_ff, fail_code_in;
   logic [TICK_COUNTER_BITS-1:0] ticks_ff, ticks_in;
   logic [TIMEOUT_W-1:0]         timeout_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic                         busy, req_fire, timed_out;
   logic                         accepted, clear_error;
   logic [2:0]                   command;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign busy      = (state_ff inside {ST_FAST, ST_RETRACT, ST_SLOW, ST_APPLY});
   assign timed_out = CMP_W'(ticks_ff) > CMP_W'(timeout_ff);

   always_comb begin
      state_in       = state_ff;
      zero_valid_in  = zero_valid_ff;
      lost_reason_in = lost_reason_ff;
      fail_code_in   = fail_code_ff;
      ticks_in       = ticks_ff;
      accepted       = 1'b0;
      clear_error    = 1'b0;
      command        = CMD_NONE;
      case (req_data.func)
         FUNC_START: begin
            if (!busy) begin
               if (!req_data.link_up || req_data.machine_state != MACH_IDLE) begin
                  state_in       = ST_FAILED;
                  zero_valid_in  = 1'b0;
                  lost_reason_in = WHY_PROBE_FAILED;
                  if (!req_data.link_up) fail_code_in = FAIL_NO_LINK;
                  else if (req_data.machine_state == MACH_ALARM) fail_code_in = FAIL_ALARM;
                  else fail_code_in = FAIL_NOT_IDLE;
               end else begin
                  fail_code_in  = FAIL_NONE;
                  zero_valid_in = 1'b0;
                  state_in      = ST_FAST;
                  ticks_in      = '0;
                  accepted      = 1'b1;
                  command       = CMD_FAST_PROBE;
               end
            end
         end
         FUNC_CANCEL: begin
            if (busy) begin
               command        = CMD_FEED_HOLD;
               state_in       = ST_IDLE;
               zero_valid_in  = 1'b0;
               lost_reason_in = WHY_CANCELLED;
            end
         end
         FUNC_POLL: begin
            if (busy) begin
               if (!req_data.link_up || req_data.motion_error || timed_out) begin
                  state_in       = ST_FAILED;
                  zero_valid_in  = 1'b0;
                  lost_reason_in = WHY_PROBE_FAILED;
                  if (!req_data.link_up) fail_code_in = FAIL_LINK_LOST;
                  else if (req_data.motion_error) begin
                     fail_code_in = FAIL_CTRL_ERROR;
                     clear_error  = 1'b1;
                  end else fail_code_in = FAIL_TIMEOUT;
               end else if (req_data.queue_synced && req_data.machine_state == MACH_IDLE) begin
                  case (state_ff)
                     ST_FAST, ST_SLOW: begin
                        if (req_data.probe_result_ready) begin
                           if (!req_data.probe_triggered) begin
                              state_in       = ST_FAILED;
                              zero_valid_in  = 1'b0;
                              lost_reason_in = WHY_PROBE_FAILED;
                              fail_code_in   = (state_ff == ST_FAST) ? FAIL_NO_FAST
                                                                     : FAIL_NO_SLOW;
                           end else begin
                              state_in = (state_ff == ST_FAST) ? ST_RETRACT : ST_APPLY;
                              command  = (state_ff == ST_FAST) ? CMD_RETRACT : CMD_APPLY;
                              ticks_in = '0;
                           end
                        end
                     end
                     ST_RETRACT: begin
                        state_in = ST_SLOW;
                        command  = CMD_SLOW_PROBE;
                        ticks_in = '0;
                     end
                     ST_APPLY: begin
                        state_in      = ST_DONE;
                        zero_valid_in = 1'b1;
                        fail_code_in  = FAIL_NONE;
                     end
                     default: ;
                  endcase
               end
            end
         end
         FUNC_SET_HERE: begin
            if (!busy && req_data.link_up) begin
               command       = CMD_SET_HERE;
               zero_valid_in = 1'b1;
               state_in      = ST_DONE;
               fail_code_in  = FAIL_SET_UNPROBED;
            end
         end
         FUNC_INVALIDATE: begin
            zero_valid_in  = 1'b0;
            lost_reason_in = (req_data.lost_cause == WHY_UNDEFINED) ? WHY_CANCELLED
                                                                    : req_data.lost_cause;
            if (busy) state_in = ST_FAILED;
         end
         FUNC_TICK: begin
            if (ticks_ff != '1) ticks_in = ticks_ff + 1'b1;
         end
         default: ;
      endcase

      rsp_data_in.accepted    = accepted;
      rsp_data_in.command     = command;
      rsp_data_in.clear_error = clear_error;
      rsp_data_in.seq_state   = state_in;
      rsp_data_in.zero_valid  = zero_valid_in;
      rsp_data_in.lost_reason = lost_reason_in;
      rsp_data_in.fail_code   = fail_code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         zero_valid_ff  <= 1'b0;
         lost_reason_ff <= WHY_NEVER_SET;
         fail_code_ff   <= FAIL_NONE;
         ticks_ff       <= '0;
         timeout_ff     <= TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) timeout_ff <= csr_wr_data;
         if (req_fire) begin
            state_ff       <= state_in;
            zero_valid_ff  <= zero_valid_in;
            lost_reason_ff <= lost_reason_in;
            fail_code_ff   <= fail_code_in;
            ticks_ff       <= ticks_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_data_ff <= rsp_data_in;
   end

   `PTOS_ASSERT_NEXT(a_fire_gives_rsp, req_fire, rsp_valid_ff, "request accepted without response")
   `PTOS_ASSERT_NOW(a_zero_only_done, zero_valid_ff, state_ff == ST_DONE, "zero valid outside done")
   `PTOS_ASSERT_NOW(a_accept_fast, rsp_valid_ff && rsp_data_ff.accepted, state_ff == ST_FAST, "accepted start not in fast probe")
   `PTOS_ASSERT_NOW(a_clear_err_code, rsp_valid_ff && rsp_data_ff.clear_error, rsp_data_ff.fail_code == FAIL_CTRL_ERROR, "clear error without controller error")

endmodule

// File: verif/touch_off_checker.sv
// Checker: predicts each touch-off response from the requests seen and compares it field by field.
`timescale 1ns / 1ps

module touch_off_checker #(
   parameter int TICK_BITS = ptos_pkg::TICK_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ptos_pkg::req_type              req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ptos_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [ptos_pkg::TIMEOUT_W-1:0] csr_wr_data,
   output int                             mismatches,
   output int                             pending,
   output int                             checked
);
   import ptos_pkg::*;

   typedef enum logic [2:0] {
      SEQ_IDLE    = 3'd0,
      SEQ_FAST    = 3'd1,
      SEQ_RETRACT = 3'd2,
      SEQ_SLOW    = 3'd3,
      SEQ_APPLY   = 3'd4,
      SEQ_DONE    = 3'd5,
      SEQ_FAILED  = 3'd6
   } seq_phase_type;

   seq_phase_type        phase;
   logic                 zero_ok;
   logic [2:0]           why_lost;
   logic [3:0]           fail_why;
   logic [TICK_BITS-1:0] ticks;
   logic [TIMEOUT_W-1:0] tick_limit;
   rsp_type              expected_q[$];

   function automatic void fail_seq(input logic [3:0] code);
      phase = SEQ_FAILED;
      zero_ok = 1'b0;
      why_lost = WHY_PROBE_FAILED;
      fail_why = code;
   endfunction

   function automatic rsp_type advance_touch_off(input req_type r);
      rsp_type o;
      logic    busy;
      o = '0;
      busy = phase inside {SEQ_FAST, SEQ_RETRACT, SEQ_SLOW, SEQ_APPLY};
      case (r.func)
         FUNC_START: begin
            if (!busy) begin
               if (!r.link_up) fail_seq(FAIL_NO_LINK);
               else if (r.machine_state == MACH_ALARM) fail_seq(FAIL_ALARM);
               else if (r.machine_state != MACH_IDLE) fail_seq(FAIL_NOT_IDLE);
               else begin
                  fail_why = FAIL_NONE;
                  zero_ok = 1'b0;
                  phase = SEQ_FAST;
                  ticks = '0;
                  o.accepted = 1'b1;
                  o.command = CMD_FAST_PROBE;
               end
            end
         end
         FUNC_CANCEL: begin
            if (busy) begin
               o.command = CMD_FEED_HOLD;
               phase = SEQ_IDLE;
               zero_ok = 1'b0;
               why_lost = WHY_CANCELLED;
            end
         end
         FUNC_POLL: begin
            if (busy) begin
               if (!r.link_up) fail_seq(FAIL_LINK_LOST);
               else if (r.motion_error) begin
                  fail_seq(FAIL_CTRL_ERROR);
                  o.clear_error = 1'b1;
               end
               else if (ticks > tick_limit) fail_seq(FAIL_TIMEOUT);
               else if (r.queue_synced && r.machine_state == MACH_IDLE) begin
                  case (phase)
                     SEQ_FAST: begin
                        if (r.probe_result_ready) begin
                           if (!r.probe_triggered) fail_seq(FAIL_NO_FAST);
                           else begin
                              phase = SEQ_RETRACT;
                              ticks = '0;
                              o.command = CMD_RETRACT;
                           end
                        end
                     end
                     SEQ_RETRACT: begin
                        phase = SEQ_SLOW;
                        ticks = '0;
                        o.command = CMD_SLOW_PROBE;
                     end
                     SEQ_SLOW: begin
                        if (r.probe_result_ready) begin
                           if (!r.probe_triggered) fail_seq(FAIL_NO_SLOW);
                           else begin
                              phase = SEQ_APPLY;
                              ticks = '0;
                              o.command = CMD_APPLY;
                           end
                        end
                     end
                     default: begin
                        phase = SEQ_DONE;
                        zero_ok = 1'b1;
                        fail_why = FAIL_NONE;
                     end
                  endcase
               end
            end
         end
         FUNC_SET_HERE: begin
            if (!busy && r.link_up) begin
               o.command = CMD_SET_HERE;
               zero_ok = 1'b1;
               phase = SEQ_DONE;
               fail_why = FAIL_SET_UNPROBED;
            end
         end
         FUNC_INVALIDATE: begin
            zero_ok = 1'b0;
            why_lost = (r.lost_cause == WHY_UNDEFINED) ? WHY_CANCELLED : r.lost_cause;
            if (busy) phase = SEQ_FAILED;
         end
         FUNC_TICK: begin
            if (ticks != '1) ticks = ticks + 1'b1;
         end
         default: ;
      endcase
      o.seq_state = phase;
      o.zero_valid = zero_ok;
      o.lost_reason = why_lost;
      o.fail_code = fail_why;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase = SEQ_IDLE;
         zero_ok = 1'b0;
         why_lost = WHY_NEVER_SET;
         fail_why = FAIL_NONE;
         ticks = '0;
         tick_limit = TIMEOUT_RESET;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("accepted", 4'(want.accepted), 4'(rsp_data.accepted));
               check_field("command", 4'(want.command), 4'(rsp_data.command));
               check_field("clear_error", 4'(want.clear_error), 4'(rsp_data.clear_error));
               check_field("seq_state", 4'(want.seq_state), 4'(rsp_data.seq_state));
               check_field("zero_valid", 4'(want.zero_valid), 4'(rsp_data.zero_valid));
               check_field("lost_reason", 4'(want.lost_reason), 4'(rsp_data.lost_reason));
               check_field("fail_code", want.fail_code, rsp_data.fail_code);
               checked++;
            end
         end
         if (req_valid && req_ready) expected_q.push_back(advance_touch_off(req_data));
         if (csr_wr_en) tick_limit = csr_wr_data;
      end
      pending = expected_q.size();
   end

endmodule

// File: verif/tb_probe_touch_off_sequencer.sv
// Testbench top: drives touch-off requests, response back-pressure and timeout writes.
`timescale 1ns / 1ps

module tb_probe_touch_off_sequencer;
   import ptos_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_REQUESTS = 1620;
   localparam int SETTING_COUNT = 7;
   localparam int LONG_HOLD = 120;
   localparam logic [1:0] MACH_OTHER = 2'd2;
   localparam logic [1:0] MACH_UNDEF = 2'd3;
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam logic [2:0] WHY_ALARM = 3'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [TIMEOUT_W-1:0] csr_wr_data;

   int mismatches;
   int pending;
   int checked;
   int cycles = 0;
   int sent = 0;
   int settings = 1;
   int hold_asks = 0;
   bit gaps_on = 1'b1;

   probe_touch_off_sequencer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   touch_off_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("cycle limit reached with %0d responses outstanding", pending);
      $display("FAIL probe_touch_off_sequencer");
      $finish;
   end

   // Response side: short random stalls, quiet stretches, and long holds on request.
   initial begin
      int stall;
      int holds_done;
      int pick;
      bit stalls_on;
      rsp_ready = 1'b0;
      stall = 0;
      holds_done = 0;
      stalls_on = 1'b1;
      @(negedge reset);
      forever begin
         if (holds_done < hold_asks) begin
            holds_done++;
            stall = LONG_HOLD;
         end else if (stall == 0 && stalls_on) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) stall = $urandom_range(1, 3);
            else if (pick < 28) stall = $urandom_range(10, 40);
         end
         if ($urandom_range(0, 199) == 0) stalls_on = !stalls_on;
         rsp_ready <= (stall == 0);
         if (stall > 0) stall--;
         @(posedge clock);
      end
   end

   function automatic int pick_gap();
      int pick;
      if ($urandom_range(0, 59) == 0) gaps_on = !gaps_on;
      if (!gaps_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called in the step of a rising edge; returns in the step of the accepting edge.
   task automatic push(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   function automatic req_type make_req(input logic [2:0] func, input logic link,
                                        input logic [1:0] mstate, input logic synced,
                                        input logic merr, input logic rdy, input logic trig,
                                        input logic [2:0] cause);
      req_type r;
      r.func = func;
      r.link_up = link;
      r.machine_state = mstate;
      r.queue_synced = synced;
      r.motion_error = merr;
      r.probe_result_ready = rdy;
      r.probe_triggered = trig;
      r.lost_cause = cause;
      return r;
   endfunction

   function automatic req_type noise_req();
      req_type r;
      if ($urandom_range(0, 19) == 0) r.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
      else r.func = 3'($urandom_range(FUNC_START, FUNC_TICK));
      r.link_up = $urandom_range(0, 9) != 0;
      r.machine_state = 2'($urandom_range(MACH_IDLE, MACH_UNDEF));
      r.queue_synced = 1'($urandom_range(0, 1));
      r.motion_error = $urandom_range(0, 7) == 0;
      r.probe_result_ready = 1'($urandom_range(0, 1));
      r.probe_triggered = 1'($urandom_range(0, 1));
      r.lost_cause = 3'($urandom_range(WHY_NEVER_SET, WHY_UNDEFINED));
      return r;
   endfunction

   function automatic req_type good_poll();
      return make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, $urandom_range(0, 9) != 0,
                      $urandom_range(0, 11) != 0,
                      3'($urandom_range(WHY_NEVER_SET, WHY_UNDEFINED)));
   endfunction

   // One touch-off attempt: a start followed by mostly clean polls, ticks and some noise.
   task automatic touch_off_run();
      req_type r;
      int      pick;
      r = noise_req();
      r.func = FUNC_START;
      if ($urandom_range(0, 99) < 85) begin
         r.link_up = 1'b1;
         r.machine_state = MACH_IDLE;
      end
      push(r);
      repeat ($urandom_range(4, 14)) begin
         pick = $urandom_range(0, 99);
         r = noise_req();
         if (pick < 50) push(good_poll());
         else if (pick < 62) begin
            r.func = FUNC_POLL;
            push(r);
         end else if (pick < 80) begin
            r.func = FUNC_TICK;
            push(r);
         end else if (pick < 84) begin
            repeat ($urandom_range(2, 12)) begin
               r = noise_req();
               r.func = FUNC_TICK;
               push(r);
            end
         end else push(r);
      end
   endtask

   initial begin
      logic [TIMEOUT_W-1:0] limits [SETTING_COUNT];
      int                   base;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b0, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_ALARM, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_OTHER, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_UNDEF, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_SET_HERE, 1'b0, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_SET_HERE, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_INVALIDATE, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_UNDEFINED));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b0, 1'b0, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_TICK, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b0, MACH_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_POLL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b1, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_CANCEL, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_START, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));
      push(make_req(FUNC_INVALIDATE, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_ALARM));
      push(make_req(FUNC_SPARE_LO, 1'b1, MACH_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, WHY_NEVER_SET));

      limits = '{TIMEOUT_RESET, 20'd1, 20'd0, 20'hFFFFF, 20'd1000000,
                 20'($urandom_range(2, 10)), 20'($urandom_range(2, 10))};
      base = sent;
      for (int p = 0; p < SETTING_COUNT; p++) begin
         if (p > 0) set_timeout(limits[p]);
         if (p == 1 || p == 4) hold_asks++;
         while (sent < base + (p + 1) * RANDOM_REQUESTS / SETTING_COUNT) begin
            if ($urandom_range(0, 99) < 85) touch_off_run();
            else push(noise_req());
         end
      end

      drain();
      $display("%0d requests over %0d step timeout settings, %0d responses checked",
               sent, settings, checked);
      $display("%0d long response holds applied while requests kept coming", hold_asks);
      if (mismatches == 0) $display("PASS probe_touch_off_sequencer");
      else $display("FAIL probe_touch_off_sequencer");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/ptos_pkg.sv
design/probe_touch_off_sequencer.sv
verif/touch_off_checker.sv
verif/tb_probe_touch_off_sequencer.sv
